### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while in reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

### rtl/rtufr_pkg.sv
// ----------------------------------------------------------------------------
// rtufr_pkg
// Types, constants and the CRC-16 byte fold for the RTU frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package rtufr_pkg;

  // buffer limit and derived byte counter width
  localparam int MAX_FRAME_BYTES = 256;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  // frame layout
  localparam int          MIN_FRAME_BYTES = 11;
  localparam int          CTRL_BYTE_IDX   = 8;
  localparam logic [7:0]  HDR_ADDR        = 8'h02;
  localparam logic [7:0]  HDR_FUNC        = 8'h10;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // gap threshold after reset
  localparam logic [15:0] GAP_RESET_MS = 16'd5;

  // operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result status codes
  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_FRAME  = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;

  // control nibble codes
  localparam logic [3:0] NIB_DRAIN  = 4'h1;
  localparam logic [3:0] NIB_COOLER = 4'h2;
  localparam logic [3:0] NIB_BOTH   = 4'h3;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] frame_length;
    logic [7:0]       ctrl_octet;
    logic             power_on;
    logic [3:0]       fan_level;
    logic             drain_flag;
    logic             cooler_flag;
  } result_t;

  // one byte folded into the reflected crc, bit by bit
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/rtufr_frame.sv
// ----------------------------------------------------------------------------
// rtufr_frame
// Frame state: idle timer, byte counter, delayed crc, header and control
// byte; forms the result of the item in the input register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtufr_frame import rtufr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        op,
  input  wire logic [7:0]  data,
  input  wire logic [15:0] gap_ms,
  output result_t          res
);

  logic [15:0]      idle_r,  idle_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r,   crc_nxt;
  logic [15:0]      recent_r, recent_nxt;
  logic             hdr_r,   hdr_nxt;
  logic [7:0]       ctrl_r,  ctrl_nxt;

  logic             gap;
  logic [CNT_W-1:0] n;
  logic [15:0]      crc_e, recent_e;
  logic             hdr_e;
  logic [7:0]       ctrl_e;
  logic             full, accept;

  // next state and result for one item
  always_comb begin
    idle_nxt   = idle_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    recent_nxt = recent_r;
    hdr_nxt    = hdr_r;
    ctrl_nxt   = ctrl_r;
    res        = '0;
    accept     = 1'b0;

    // silence longer than the threshold restarts the frame
    gap      = (idle_r > gap_ms);
    n        = gap ? '0       : count_r;
    crc_e    = gap ? CRC_INIT : crc_r;
    recent_e = gap ? 16'h0000 : recent_r;
    hdr_e    = gap ? 1'b0     : hdr_r;
    ctrl_e   = gap ? 8'h00    : ctrl_r;
    full     = (n >= CNT_W'(MAX_FRAME_BYTES));

    if (op == OP_TICK) begin
      if (idle_r != 16'hFFFF) begin
        idle_nxt = idle_r + 16'd1;
      end
    end else begin
      idle_nxt = 16'h0000;
      if (full) begin
        // dropped byte, frame restarts
        count_nxt  = '0;
        crc_nxt    = CRC_INIT;
        recent_nxt = 16'h0000;
        hdr_nxt    = 1'b0;
        ctrl_nxt   = 8'h00;
        res.status = ST_DROP;
      end else begin
        crc_nxt = (n >= CNT_W'(2)) ? crc16_fold(crc_e, recent_e[15:8]) : crc_e;
        if (n == '0) begin
          hdr_nxt = (data == HDR_ADDR);
        end else if (n == CNT_W'(1)) begin
          hdr_nxt = hdr_e && (data == HDR_FUNC);
        end else begin
          hdr_nxt = hdr_e;
        end
        ctrl_nxt   = (n == CNT_W'(CTRL_BYTE_IDX)) ? data : ctrl_e;
        recent_nxt = {recent_e[7:0], data};
        count_nxt  = n + CNT_W'(1);

        // crc trails by two bytes: last two bytes must equal it, low first
        accept = (count_nxt >= CNT_W'(MIN_FRAME_BYTES)) && hdr_nxt &&
                 (recent_nxt[15:8] == crc_nxt[7:0]) &&
                 (recent_nxt[7:0] == crc_nxt[15:8]);

        res.status = ST_STORED;
        if (accept) begin
          res.status       = ST_FRAME;
          res.frame_length = count_nxt;
          res.ctrl_octet   = ctrl_nxt;
          res.power_on     = (ctrl_nxt != 8'h00);
          res.fan_level    = ctrl_nxt[7:4];
          res.drain_flag   = (ctrl_nxt[3:0] == NIB_DRAIN) || (ctrl_nxt[3:0] == NIB_BOTH);
          res.cooler_flag  = (ctrl_nxt[3:0] == NIB_COOLER) || (ctrl_nxt[3:0] == NIB_BOTH);
          count_nxt  = '0;
          crc_nxt    = CRC_INIT;
          recent_nxt = 16'h0000;
          hdr_nxt    = 1'b0;
          ctrl_nxt   = 8'h00;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r   <= 16'h0000;
      count_r  <= '0;
      crc_r    <= CRC_INIT;
      recent_r <= 16'h0000;
      hdr_r    <= 1'b0;
      ctrl_r   <= 8'h00;
    end else if (step) begin
      idle_r   <= idle_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      recent_r <= recent_nxt;
      hdr_r    <= hdr_nxt;
      ctrl_r   <= ctrl_nxt;
    end
  end

  // the counter stays within the buffer, and a restart leaves the crc at its seed
  `ASSERT_NEVER(a_count_range, count_r > CNT_W'(MAX_FRAME_BYTES), "byte count beyond buffer")
  `ASSERT_CLK(a_restart_seed, (count_r < CNT_W'(3)) |-> (crc_r == CRC_INIT), "crc not at seed")
  // a tick leaves the byte count alone
  `ASSERT_CLK(a_tick_keeps, (step && op == OP_TICK) |=> $stable(count_r), "tick changed count")

endmodule

`default_nettype wire

### rtl/rtu_frame_receiver_crc_check.sv
// ----------------------------------------------------------------------------
// rtu_frame_receiver_crc_check
// RTU frame receiver: bytes and millisecond ticks in, one result per byte
// out, frames checked against CRC-16/MODBUS and byte 8 decoded.
//
//   channel  direction  ports                       handshake
//   in       input      in_operation, in_data_byte  in_valid / in_ready
//   out      output     out_status .. out_cooler    out_valid / out_ready
//   cfg      input      cfg_wr_data                 cfg_wr_en, no wait
//
// One item per cycle unless out_ready holds a result; a byte's result
// goes via the input register, then the result register; a tick gives none.
// The crc fold of one byte sits between the input and result registers.
// Synchronous active-low reset; no clearing pass, ready from the first cycle
// after reset. While a result waits, a byte in the input register waits with
// it and the input stalls; ticks still pass through the input register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtu_frame_receiver_crc_check import rtufr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_operation,
  input  wire logic [7:0]       in_data_byte,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic [CNT_W-1:0]      out_frame_length,
  output logic [7:0]            out_ctrl_octet,
  output logic                  out_power_on,
  output logic [3:0]            out_fan_level,
  output logic                  out_drain_flag,
  output logic                  out_cooler_flag,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [15:0]      cfg_wr_data
);

  logic        in_vld_r;
  logic        op_r;
  logic [7:0]  data_r;
  logic        out_vld_r;
  result_t     out_res_r;
  logic [15:0] gap_r;
  logic        adv;
  result_t     res;

  // the input register moves on if it holds a tick or the result slot frees
  assign adv      = in_vld_r && ((op_r == OP_TICK) || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // gap threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET_MS;
    end else if (cfg_wr_en) begin
      gap_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      data_r <= in_data_byte;
    end
  end

  // frame state and result logic
  rtufr_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .op     (op_r),
    .data   (data_r),
    .gap_ms (gap_r),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && op_r == OP_BYTE) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && op_r == OP_BYTE) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_res_r.status;
  assign out_frame_length = out_res_r.frame_length;
  assign out_ctrl_octet   = out_res_r.ctrl_octet;
  assign out_power_on     = out_res_r.power_on;
  assign out_fan_level    = out_res_r.fan_level;
  assign out_drain_flag   = out_res_r.drain_flag;
  assign out_cooler_flag  = out_res_r.cooler_flag;

  // a held item keeps its slot and operation
  `ASSERT_CLK(a_hold_item, (in_vld_r && !adv) |=> (in_vld_r && $stable(op_r)), "held item lost")
  // a tick never produces a result
  `ASSERT_CLK(a_tick_silent, (adv && op_r == OP_TICK && out_ready) |=> !out_vld_r,
              "tick produced a result")
  // fields beyond status are zero unless a frame was accepted
  `ASSERT_CLK(a_zero_fields, (out_vld_r && out_res_r.status != ST_FRAME) |->
              (out_res_r.frame_length == '0 && out_res_r.ctrl_octet == 8'h00),
              "non-frame result carries fields")

endmodule

`default_nettype wire

### dv/tb_rtu_frame_receiver_crc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtu_frame_receiver_crc_check
// Self-checking bench for the RTU frame receiver. A queue-fed driver offers
// bytes and millisecond ticks, and a line-level copy of the receiver predicts
// the result of every byte: silence gaps, full buffer drops, header and
// CRC-16 checks and the decoded control byte. A monitor compares each result
// field by field. The run goes through several gap thresholds and idling
// mixes, a long receiver hold-off, a full buffer and the largest threshold.
// ----------------------------------------------------------------------------

module tb_rtu_frame_receiver_crc_check;
  import rtufr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 56;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } bus_item_t;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_HEADER} frame_flaw_t;

  // block ports
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_operation = OP_TICK;
  logic [7:0]       in_data_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_status;
  logic [CNT_W-1:0] out_frame_length;
  logic [7:0]       out_ctrl_octet;
  logic             out_power_on;
  logic [3:0]       out_fan_level;
  logic             out_drain_flag;
  logic             out_cooler_flag;
  logic             cfg_wr_en = 1'b0;
  logic [15:0]      cfg_wr_data = 16'h0000;

  // stimulus and scoreboard state
  bus_item_t bus_items_q[$];
  result_t   rx_results_due[$];
  bus_item_t next_item;
  int        items_staged = 0;
  int        items_taken = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  int        sink_hold_goal = 0;
  int        sink_hold_done = 0;

  // receiver state as the bench sees it
  logic [15:0]      rx_gap_ms = GAP_RESET_MS;
  logic [15:0]      rx_idle_ms = 16'd0;
  logic [CNT_W-1:0] rx_count = '0;
  logic [15:0]      rx_crc = CRC_INIT;
  logic [15:0]      rx_tail = 16'd0;
  logic             rx_hdr_ok = 1'b0;
  logic [7:0]       rx_ctrl = 8'h00;

  int        src_plan[4] = '{0, 54, 0, 29};
  int        sink_plan[4] = '{0, 0, 54, 29};
  int        gap_plan[4] = '{5, 0, 3, 0};

  rtu_frame_receiver_crc_check dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_ctrl_octet   (out_ctrl_octet),
    .out_power_on     (out_power_on),
    .out_fan_level    (out_fan_level),
    .out_drain_flag   (out_drain_flag),
    .out_cooler_flag  (out_cooler_flag),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // reflected crc-16, one data bit at a time
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    error_count++;
    if (error_count <= 30) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  task automatic rx_restart();
    rx_count = '0;
    rx_crc = CRC_INIT;
    rx_tail = 16'd0;
    rx_hdr_ok = 1'b0;
    rx_ctrl = 8'h00;
  endtask

  // one accepted item through the receiver; bytes queue their result
  task automatic rx_frame_step(input logic op, input logic [7:0] b);
    result_t          res;
    logic [CNT_W-1:0] n;
    logic [3:0]       lo;
    if (op == OP_TICK) begin
      if (rx_idle_ms != 16'hFFFF) begin
        rx_idle_ms = rx_idle_ms + 16'd1;
      end
      return;
    end
    res = '0;
    if (rx_idle_ms > rx_gap_ms) begin
      rx_restart();
    end
    rx_idle_ms = 16'd0;
    // byte meeting a full buffer is dropped
    if (rx_count >= MAX_FRAME_BYTES) begin
      rx_restart();
      res.status = ST_DROP;
      rx_results_due.push_back(res);
      return;
    end
    n = rx_count;
    if (n >= 2) begin
      rx_crc = crc_step(rx_crc, rx_tail[15:8]);
    end
    if (n == 0) begin
      rx_hdr_ok = (b == HDR_ADDR);
    end else if (n == 1) begin
      rx_hdr_ok = rx_hdr_ok && (b == HDR_FUNC);
    end
    if (n == CTRL_BYTE_IDX) begin
      rx_ctrl = b;
    end
    rx_tail = {rx_tail[7:0], b};
    rx_count = n + 1'b1;
    // frame complete when the last two bytes carry the crc, low byte first
    if (rx_count >= MIN_FRAME_BYTES && rx_hdr_ok &&
        rx_tail[15:8] == rx_crc[7:0] && rx_tail[7:0] == rx_crc[15:8]) begin
      lo = rx_ctrl[3:0];
      res.status       = ST_FRAME;
      res.frame_length = rx_count;
      res.ctrl_octet   = rx_ctrl;
      res.power_on     = (rx_ctrl != 8'h00);
      res.fan_level    = rx_ctrl[7:4];
      res.drain_flag   = (lo == NIB_DRAIN) || (lo == NIB_BOTH);
      res.cooler_flag  = (lo == NIB_COOLER) || (lo == NIB_BOTH);
      rx_restart();
    end else begin
      res.status = ST_STORED;
    end
    rx_results_due.push_back(res);
  endtask

  task automatic check_result();
    result_t want;
    if (rx_results_due.size() == 0) begin
      note_mismatch("result with nothing pending, status", out_status, -1);
      return;
    end
    want = rx_results_due.pop_front();
    if (out_status !== want.status)
      note_mismatch("status", out_status, want.status);
    if (out_frame_length !== want.frame_length)
      note_mismatch("frame_length", out_frame_length, want.frame_length);
    if (out_ctrl_octet !== want.ctrl_octet)
      note_mismatch("ctrl_octet", out_ctrl_octet, want.ctrl_octet);
    if (out_power_on !== want.power_on)
      note_mismatch("power_on", out_power_on, want.power_on);
    if (out_fan_level !== want.fan_level)
      note_mismatch("fan_level", out_fan_level, want.fan_level);
    if (out_drain_flag !== want.drain_flag)
      note_mismatch("drain_flag", out_drain_flag, want.drain_flag);
    if (out_cooler_flag !== want.cooler_flag)
      note_mismatch("cooler_flag", out_cooler_flag, want.cooler_flag);
  endtask

  // input driver: payload held until the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rx_frame_step(in_operation, in_data_byte);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (bus_items_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_item = bus_items_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= next_item.op;
          in_data_byte <= next_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (sink_hold_done < sink_hold_goal) begin
      sink_hold_done <= sink_hold_done + 1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (sink_hold_done < sink_hold_goal) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_item(input logic op, input logic [7:0] data);
    bus_items_q.push_back(bus_item_t'{op: op, data: data});
    items_staged++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(OP_BYTE, b);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(OP_TICK, 8'($urandom_range(255)));
  endtask

  // all items transferred, all results in, pipeline settled
  task automatic wait_until_quiet();
    do begin
      @(posedge clk);
    end while (items_taken != items_staged || rx_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(input logic [15:0] ms);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ms;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rx_gap_ms = ms;
  endtask

  function automatic logic [7:0] pick_control();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3, 4,
      5, 6:    return {4'($urandom_range(15)), 4'($urandom_range(3))};
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // frame with header, control byte and crc; optional flaw and mid-frame pause
  task automatic send_frame(input int len, input logic [7:0] ctrl, input frame_flaw_t flaw,
                            input int pause_at, input int pause_len);
    logic [7:0]  octets[0:MAX_FRAME_BYTES-1];
    logic [15:0] acc;
    int          quiet_max;
    int          flip_at;
    int          flip_pos;
    acc = CRC_INIT;
    quiet_max = (rx_gap_ms > 16'd3) ? 3 : int'(rx_gap_ms);
    // silence long enough to start a fresh frame, when the threshold is below 64
    if (rx_gap_ms < 16'd64) begin
      push_ticks(int'(rx_gap_ms) + 1 + $urandom_range(2));
    end
    for (int i = 0; i < len; i++) begin
      octets[i] = 8'($urandom_range(255));
    end
    octets[0] = HDR_ADDR;
    octets[1] = HDR_FUNC;
    octets[CTRL_BYTE_IDX] = ctrl;
    if (flaw == FLAW_HEADER) begin
      flip_at = $urandom_range(1);
      flip_pos = $urandom_range(7);
      octets[flip_at][flip_pos] = ~octets[flip_at][flip_pos];
    end
    for (int i = 0; i < len - 2; i++) begin
      acc = crc_step(acc, octets[i]);
    end
    octets[len-2] = acc[7:0];
    octets[len-1] = acc[15:8];
    if (flaw == FLAW_CRC) begin
      flip_at = len - 2 + $urandom_range(1);
      flip_pos = $urandom_range(7);
      octets[flip_at][flip_pos] = ~octets[flip_at][flip_pos];
    end
    // short silences inside the frame stay within the threshold
    for (int i = 0; i < len; i++) begin
      if (i == pause_at) begin
        push_ticks(pause_len);
      end else if (i > 0 && quiet_max > 0 && $urandom_range(4) == 0) begin
        push_ticks($urandom_range(quiet_max, 1));
      end
      push_byte(octets[i]);
    end
  endtask

  // mostly well-formed frames, the rest broken frames and noise
  task automatic random_traffic(input int count);
    int base;
    int sel;
    int len;
    base = items_staged;
    while (items_staged - base < count) begin
      sel = $urandom_range(99);
      len = ($urandom_range(19) == 0) ? $urandom_range(80, 19) : $urandom_range(18, 11);
      if (sel < 62) begin
        send_frame(len, pick_control(), FLAW_NONE, -1, 0);
      end else if (sel < 70) begin
        send_frame(len, pick_control(), FLAW_CRC, -1, 0);
      end else if (sel < 76) begin
        send_frame(len, pick_control(), FLAW_HEADER, -1, 0);
      end else if (sel < 83) begin
        // silence inside the frame breaks it
        send_frame(len, pick_control(), FLAW_NONE, $urandom_range(len - 1, 1),
                   int'(rx_gap_ms) + 1);
      end else if (sel < 90) begin
        push_ticks(int'(rx_gap_ms) + 1);
        push_byte(HDR_ADDR);
        push_byte(HDR_FUNC);
        repeat ($urandom_range(8)) push_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(4, 1)) push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, ticks, a clean frame at the reset threshold
    push_byte(8'hFF);
    push_byte(8'h00);
    send_frame(MIN_FRAME_BYTES, 8'h13, FLAW_NONE, -1, 0);

    // random phases with different thresholds and idling
    for (int p = 0; p < 4; p++) begin
      wait_until_quiet();
      write_gap((p == 3) ? 16'($urandom_range(8, 1)) : 16'(gap_plan[p]));
      src_idle_pct = src_plan[p];
      sink_stall_pct = sink_plan[p];
      if (p == 0) begin
        // receiver holds off while the sender keeps offering
        sink_hold_goal = sink_hold_done + 300;
        random_traffic(PHASE_ITEMS / 2);
        wait_until_quiet();
        random_traffic(PHASE_ITEMS / 2);
      end else begin
        random_traffic(PHASE_ITEMS);
      end
    end

    // full buffer: 256 bytes stored, the next dropped, then a longest frame
    wait_until_quiet();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_gap(16'd0);
    push_ticks(3);
    push_byte(8'h00);
    repeat (MAX_FRAME_BYTES) push_byte(8'($urandom_range(255)));
    send_frame(MAX_FRAME_BYTES, pick_control(), FLAW_NONE, -1, 0);

    // largest threshold: a long silence inside the frame does not restart it
    wait_until_quiet();
    write_gap(16'hFFFF);
    send_frame(MIN_FRAME_BYTES, pick_control(), FLAW_NONE, 5, 40);

    wait_until_quiet();
    repeat (10) @(posedge clk);
    if (rx_results_due.size() != 0) begin
      note_mismatch("results never delivered", rx_results_due.size(), 0);
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rtufr_pkg.sv
rtl/rtufr_frame.sv
rtl/rtu_frame_receiver_crc_check.sv
dv/tb_rtu_frame_receiver_crc_check.sv
